>>> rtl/cscr_pkg.sv
// Shared types and constants for the crop/scale YCbCr to RGB block.
// No dependencies; the front, the back, the top and the testbench refer to it by scoped names.
package cscr_pkg;

    // Width of the output frame buffer in pixels (row pitch for dest_index)
    localparam int unsigned OUT_COLS = 320;

    // Field widths
    localparam int unsigned SRC_W   = 12;
    localparam int unsigned COL_W   = 9;
    localparam int unsigned ROW_W   = 8;
    localparam int unsigned DEST_W  = 17;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COLOR_W = 24;

    // Dividend widths of the two source-coordinate divisions
    localparam int unsigned NUM_X_W = COL_W + SRC_W;
    localparam int unsigned NUM_Y_W = ROW_W + SRC_W;

    // Reset values of the geometry registers
    localparam logic [SRC_W-1:0] CROP_WIDTH_RST   = 12'd320;
    localparam logic [SRC_W-1:0] CROP_HEIGHT_RST  = 12'd240;
    localparam logic [COL_W-1:0] PLACE_WIDTH_RST  = 9'd320;
    localparam logic [ROW_W-1:0] PLACE_HEIGHT_RST = 8'd240;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CROP_LEFT    = 3'd0,
        CFG_CROP_TOP     = 3'd1,
        CFG_CROP_WIDTH   = 3'd2,
        CFG_CROP_HEIGHT  = 3'd3,
        CFG_PLACE_LEFT   = 3'd4,
        CFG_PLACE_TOP    = 3'd5,
        CFG_PLACE_WIDTH  = 3'd6,
        CFG_PLACE_HEIGHT = 3'd7
    } t_cfg_index;

    // Geometry registers as seen by both halves
    typedef struct packed {
        logic [SRC_W-1:0] crop_left;
        logic [SRC_W-1:0] crop_top;
        logic [SRC_W-1:0] crop_width;
        logic [SRC_W-1:0] crop_height;
        logic [COL_W-1:0] place_left;
        logic [ROW_W-1:0] place_top;
        logic [COL_W-1:0] place_width;
        logic [ROW_W-1:0] place_height;
    } t_cfg;

    // One classified pixel traveling from the front to the back
    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [PIX_W-1:0]  cb;
        logic [PIX_W-1:0]  cr;
        logic [DEST_W-1:0] dest;
        logic              last;
        logic [COL_W-1:0]  next_col;
        logic [ROW_W-1:0]  next_row;
    } t_entry;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

>>> rtl/cscr_pix_if.sv
// Input channel: one beat carries the luma and chroma bytes of one pixel.
// No dependencies.
interface cscr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_sample;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;

    modport source (output valid, output luma_sample, output chroma_blue,
                    output chroma_red, input ready);
    modport sink   (input valid, input luma_sample, input chroma_blue,
                    input chroma_red, output ready);
endinterface

>>> rtl/cscr_rgb_if.sv
// Output channel: one beat carries a converted pixel and its addressing.
// No dependencies.
interface cscr_rgb_if;
    logic        valid;
    logic        ready;
    logic [23:0] color;
    logic [16:0] dest_index;
    logic [11:0] next_src_x;
    logic [11:0] next_src_y;
    logic        frame_last;

    modport source (output valid, output color, output dest_index,
                    output next_src_x, output next_src_y, output frame_last,
                    input ready);
    modport sink   (input valid, input color, input dest_index,
                    input next_src_x, input next_src_y, input frame_last,
                    output ready);
endinterface

>>> rtl/cscr_fifo.sv
// Small flip-flop queue between the front and back halves.
// Depends on nothing but its parameters.
module cscr_fifo #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Store incoming beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/cscr_div.sv
// Restoring divider, one quotient bit per cycle, for source coordinates.
// Depends on nothing but its parameters.
module cscr_div #(
    parameter int unsigned NUM_W = 21,
    parameter int unsigned DEN_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        shifted = {r_rem, r_quot[NUM_W-1]};
        ge      = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

    // Datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (o_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

>>> rtl/cscr_front.sv
// Front half: geometry registers, input acceptance and raster walk.
// Depends on cscr_pkg and cscr_pix_if.
module cscr_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [11:0]             i_cfg_data,
    cscr_pix_if.sink                i_pix,
    input  logic                    i_full,
    output logic                    o_push,
    output cscr_pkg::t_entry        o_entry,
    output cscr_pkg::t_cfg          o_cfg
);
    cscr_pkg::t_cfg                     r_cfg;
    logic [cscr_pkg::COL_W-1:0]         r_col;
    logic [cscr_pkg::ROW_W-1:0]         r_row;
    logic [cscr_pkg::COL_W-1:0]         n_col;
    logic [cscr_pkg::ROW_W-1:0]         n_row;
    logic [cscr_pkg::COL_W-1:0]         pw;
    logic [cscr_pkg::ROW_W-1:0]         ph;
    logic [cscr_pkg::COL_W:0]           col_inc;
    logic [cscr_pkg::ROW_W:0]           row_inc;
    logic                               wrap_col;
    logic                               wrap_row;
    logic [cscr_pkg::COL_W-1:0]         row_sum;
    logic [cscr_pkg::DEST_W-1:0]        dest;

    assign o_cfg       = r_cfg;
    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    // Write geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crop_left    <= '0;
            r_cfg.crop_top     <= '0;
            r_cfg.crop_width   <= cscr_pkg::CROP_WIDTH_RST;
            r_cfg.crop_height  <= cscr_pkg::CROP_HEIGHT_RST;
            r_cfg.place_left   <= '0;
            r_cfg.place_top    <= '0;
            r_cfg.place_width  <= cscr_pkg::PLACE_WIDTH_RST;
            r_cfg.place_height <= cscr_pkg::PLACE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (cscr_pkg::t_cfg_index'(i_cfg_index))
                cscr_pkg::CFG_CROP_LEFT:    r_cfg.crop_left    <= i_cfg_data;
                cscr_pkg::CFG_CROP_TOP:     r_cfg.crop_top     <= i_cfg_data;
                cscr_pkg::CFG_CROP_WIDTH:   r_cfg.crop_width   <= i_cfg_data;
                cscr_pkg::CFG_CROP_HEIGHT:  r_cfg.crop_height  <= i_cfg_data;
                cscr_pkg::CFG_PLACE_LEFT:   r_cfg.place_left   <= i_cfg_data[8:0];
                cscr_pkg::CFG_PLACE_TOP:    r_cfg.place_top    <= i_cfg_data[7:0];
                cscr_pkg::CFG_PLACE_WIDTH:  r_cfg.place_width  <= i_cfg_data[8:0];
                cscr_pkg::CFG_PLACE_HEIGHT: r_cfg.place_height <= i_cfg_data[7:0];
            endcase
        end
    end

    // Step the raster position; a zero size counts as one
    always_comb begin
        pw       = (r_cfg.place_width == '0) ? 9'd1 : r_cfg.place_width;
        ph       = (r_cfg.place_height == '0) ? 8'd1 : r_cfg.place_height;
        col_inc  = {1'b0, r_col} + 10'd1;
        row_inc  = {1'b0, r_row} + 9'd1;
        wrap_col = (col_inc >= {1'b0, pw});
        wrap_row = (row_inc >= {1'b0, ph});
        n_col    = wrap_col ? '0 : col_inc[cscr_pkg::COL_W-1:0];
        if (!wrap_col) begin
            n_row = r_row;
        end else if (wrap_row) begin
            n_row = '0;
        end else begin
            n_row = row_inc[cscr_pkg::ROW_W-1:0];
        end
    end

    // Frame-buffer index of the current pixel, modulo the index width
    always_comb begin
        row_sum = {1'b0, r_cfg.place_top} + {1'b0, r_row};
        dest    = cscr_pkg::DEST_W'(row_sum) * cscr_pkg::DEST_W'(cscr_pkg::OUT_COLS)
                + cscr_pkg::DEST_W'(r_cfg.place_left) + cscr_pkg::DEST_W'(r_col);
    end

    // Pack the classified beat for the back half
    always_comb begin
        o_entry.luma     = i_pix.luma_sample;
        o_entry.cb       = i_pix.chroma_blue;
        o_entry.cr       = i_pix.chroma_red;
        o_entry.dest     = dest;
        o_entry.last     = wrap_col && wrap_row;
        o_entry.next_col = n_col;
        o_entry.next_row = n_row;
    end

    // Advance position on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> rtl/cscr_back.sv
// Back half: color conversion, source-coordinate division, output register.
// Depends on cscr_pkg, cscr_rgb_if and cscr_div.
module cscr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  cscr_pkg::t_entry     i_entry,
    input  cscr_pkg::t_cfg       i_cfg,
    output logic                 o_pop,
    cscr_rgb_if.source           o_rgb
);
    cscr_pkg::t_back_state            r_state, n_state;
    cscr_pkg::t_entry                 r_ent;
    logic signed [26:0]               r_py, r_pr, r_pg, r_pb;
    logic [cscr_pkg::COLOR_W-1:0]     r_color;
    logic                             r_out_valid;
    logic [cscr_pkg::COLOR_W-1:0]     r_out_color;
    logic [cscr_pkg::DEST_W-1:0]      r_out_dest;
    logic [cscr_pkg::SRC_W-1:0]       r_out_x, r_out_y;
    logic                             r_out_last;

    logic                             div_start;
    logic                             load;
    logic [cscr_pkg::COL_W-1:0]       pw;
    logic [cscr_pkg::ROW_W-1:0]       ph;
    logic [cscr_pkg::NUM_X_W-1:0]     num_x, quot_x;
    logic [cscr_pkg::NUM_Y_W-1:0]     num_y, quot_y;
    logic                             x_busy, y_busy;
    logic signed [9:0]                y_off;
    logic signed [8:0]                cbv, crv;
    logic signed [10:0]               yy, rd, gd, bd;
    logic signed [11:0]               red_s, grn_s, blu_s;

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 12'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cscr_pkg::S_IDLE: if (!i_empty) n_state = cscr_pkg::S_MUL;
            cscr_pkg::S_MUL:  n_state = cscr_pkg::S_DIV;
            cscr_pkg::S_DIV:  if (!x_busy && !y_busy) n_state = cscr_pkg::S_DONE;
            cscr_pkg::S_DONE: if (!r_out_valid || o_rgb.ready) n_state = cscr_pkg::S_IDLE;
            default:          n_state = cscr_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        load      = 1'b0;
        unique case (r_state)
            cscr_pkg::S_IDLE: o_pop = !i_empty;
            cscr_pkg::S_MUL:  div_start = 1'b1;
            cscr_pkg::S_DIV:  ;
            cscr_pkg::S_DONE: load = !r_out_valid || o_rgb.ready;
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cscr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the popped beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    // Dividends and divisors for the next source coordinates
    always_comb begin
        pw    = (i_cfg.place_width == '0) ? 9'd1 : i_cfg.place_width;
        ph    = (i_cfg.place_height == '0) ? 8'd1 : i_cfg.place_height;
        num_x = cscr_pkg::NUM_X_W'(r_ent.next_col) * cscr_pkg::NUM_X_W'(i_cfg.crop_width);
        num_y = cscr_pkg::NUM_Y_W'(r_ent.next_row) * cscr_pkg::NUM_Y_W'(i_cfg.crop_height);
    end

    cscr_div #(
        .NUM_W (cscr_pkg::NUM_X_W),
        .DEN_W (cscr_pkg::COL_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_x),
        .i_den   (pw),
        .o_busy  (x_busy),
        .o_quot  (quot_x)
    );

    cscr_div #(
        .NUM_W (cscr_pkg::NUM_Y_W),
        .DEN_W (cscr_pkg::ROW_W)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_y),
        .i_den   (ph),
        .o_busy  (y_busy),
        .o_quot  (quot_y)
    );

    // Offset the samples around their zero points
    always_comb begin
        y_off = $signed({2'b00, r_ent.luma}) - 10'sd16;
        cbv   = $signed({1'b0, r_ent.cb}) - 9'sd128;
        crv   = $signed({1'b0, r_ent.cr}) - 9'sd128;
    end

    // Register the BT.601 products
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_py <= 27'(y_off) * 27'sd76309;
            r_pr <= 27'(crv) * 27'sd104597;
            r_pg <= 27'(cbv) * 27'sd25674 + 27'(crv) * 27'sd53278;
            r_pb <= 27'(cbv) * 27'sd132201;
        end
    end

    // Drop the 16 fraction bits (floor) and clamp each channel
    always_comb begin
        yy    = r_py[26:16];
        rd    = r_pr[26:16];
        gd    = r_pg[26:16];
        bd    = r_pb[26:16];
        red_s = 12'(yy) + 12'(rd);
        grn_s = 12'(yy) - 12'(gd);
        blu_s = 12'(yy) + 12'(bd);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cscr_pkg::S_DIV) begin
            r_color <= {clamp8(red_s), clamp8(grn_s), clamp8(blu_s)};
        end
    end

    // Output register: load a finished beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_color <= r_color;
            r_out_dest  <= r_ent.dest;
            r_out_x     <= i_cfg.crop_left + quot_x[cscr_pkg::SRC_W-1:0];
            r_out_y     <= i_cfg.crop_top + quot_y[cscr_pkg::SRC_W-1:0];
            r_out_last  <= r_ent.last;
        end
    end

    assign o_rgb.valid      = r_out_valid;
    assign o_rgb.color      = r_out_color;
    assign o_rgb.dest_index = r_out_dest;
    assign o_rgb.next_src_x = r_out_x;
    assign o_rgb.next_src_y = r_out_y;
    assign o_rgb.frame_last = r_out_last;

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cscr_pkg::S_MUL) |=> (x_busy && y_busy))
        else $error("dividers not started");
    a_done_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cscr_pkg::S_DONE) |-> (!x_busy && !y_busy))
        else $error("result finished while divider busy");
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == cscr_pkg::S_MUL))
        else $error("popped beat not processed");

endmodule

>>> rtl/crop_scale_ycbcr_to_rgb.sv
// Crop, nearest-neighbor scale and BT.601 YCbCr to RGB888 conversion. Each
// input beat is one destination pixel in raster order; each output beat gives
// its clamped RGB color, frame-buffer index, last-of-frame mark and the source
// coordinates of the next pixel to fetch. The front takes a beat whenever the
// queue is not full and queues it (QUEUE_DEPTH entries); the back handles one
// pixel at a time, its two bit-serial dividers (21 steps for x) giving the
// source coordinates; it pops the next beat once the last is in the output
// register. Write the geometry registers only while no pixel is in flight.
module crop_scale_ycbcr_to_rgb #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    cscr_pix_if.sink    i_pix,
    cscr_rgb_if.source  o_rgb
);
    localparam int unsigned ENTRY_W = $bits(cscr_pkg::t_entry);

    logic              push, pop, full, empty;
    cscr_pkg::t_entry  push_entry, pop_entry;
    cscr_pkg::t_cfg    cfg;
    logic [ENTRY_W-1:0] pop_bits;

    cscr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry),
        .o_cfg       (cfg)
    );

    cscr_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_bits),
        .o_full  (full),
        .o_empty (empty)
    );

    assign pop_entry = cscr_pkg::t_entry'(pop_bits);

    cscr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (pop_entry),
        .i_cfg   (cfg),
        .o_pop   (pop),
        .o_rgb   (o_rgb)
    );

endmodule

>>> tb/crop_scale_ycbcr_to_rgb_tb.sv
`timescale 1ns / 1ps
// Testbench for crop_scale_ycbcr_to_rgb: drives pixel beats and geometry writes,
// predicts color, frame-buffer index, next source coordinates and frame end.
// Depends on cscr_pkg, cscr_pix_if, cscr_rgb_if and the block itself.
module crop_scale_ycbcr_to_rgb_tb;

    localparam int CLK_PERIOD     = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 1250;

    // BT.601 fixed-point coefficients (16 fractional bits)
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int LUMA_GAIN     = 76309;
    localparam int CR_TO_RED     = 104597;
    localparam int CB_TO_GREEN   = 25674;
    localparam int CR_TO_GREEN   = 53278;
    localparam int CB_TO_BLUE    = 132201;
    localparam int CHANNEL_MAX   = 255;

    typedef struct packed {
        logic [cscr_pkg::COLOR_W-1:0] color;
        logic [cscr_pkg::DEST_W-1:0]  dest_index;
        logic [cscr_pkg::SRC_W-1:0]   next_src_x;
        logic [cscr_pkg::SRC_W-1:0]   next_src_y;
        logic                         frame_last;
    } t_rgb_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    cscr_pix_if pix_if ();
    cscr_rgb_if rgb_if ();

    crop_scale_ycbcr_to_rgb i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_if.sink),
        .o_rgb       (rgb_if.source)
    );

    // Predicted geometry and raster position
    cscr_pkg::t_cfg             geom;
    logic [cscr_pkg::COL_W-1:0] col_pos;
    logic [cscr_pkg::ROW_W-1:0] row_pos;

    t_rgb_beat pending_pixels[$];
    int        mismatches   = 0;
    int        pixels_sent  = 0;
    int        frames_seen  = 0;
    int        settings_run = 0;
    int        idle_cycles  = 0;
    bit        steady       = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] clamp_channel(input int v);
        if (v < 0) return 8'd0;
        if (v > CHANNEL_MAX) return 8'd255;
        return 8'(v);
    endfunction

    // Convert one pixel and advance the raster walk; shifts floor toward -inf
    function automatic t_rgb_beat advance_pixel(input logic [7:0] luma,
                                                input logic [7:0] cb,
                                                input logic [7:0] cr);
        int          cbv, crv, yy, rd, gd, bd;
        int unsigned pw, ph, ncol, nrow, dest, sx, sy;
        t_rgb_beat   beat;
        cbv = int'(cb) - CHROMA_OFFSET;
        crv = int'(cr) - CHROMA_OFFSET;
        yy  = ((int'(luma) - LUMA_OFFSET) * LUMA_GAIN) >>> 16;
        rd  = (crv * CR_TO_RED) >>> 16;
        gd  = (cbv * CB_TO_GREEN + crv * CR_TO_GREEN) >>> 16;
        bd  = (cbv * CB_TO_BLUE) >>> 16;
        beat.color = {clamp_channel(yy + rd), clamp_channel(yy - gd),
                      clamp_channel(yy + bd)};

        dest = (int'(geom.place_top) + int'(row_pos)) * cscr_pkg::OUT_COLS
               + int'(geom.place_left) + int'(col_pos);
        beat.dest_index = dest[cscr_pkg::DEST_W-1:0];

        // Zero destination size behaves as one
        pw = (geom.place_width == '0) ? 1 : int'(geom.place_width);
        ph = (geom.place_height == '0) ? 1 : int'(geom.place_height);
        ncol = int'(col_pos) + 1;
        nrow = int'(row_pos);
        beat.frame_last = 1'b0;
        if (ncol >= pw) begin
            ncol = 0;
            nrow = int'(row_pos) + 1;
            if (nrow >= ph) begin
                nrow = 0;
                beat.frame_last = 1'b1;
            end
        end
        col_pos = ncol[cscr_pkg::COL_W-1:0];
        row_pos = nrow[cscr_pkg::ROW_W-1:0];

        sx = int'(geom.crop_left) + (int'(col_pos) * int'(geom.crop_width)) / pw;
        sy = int'(geom.crop_top) + (int'(row_pos) * int'(geom.crop_height)) / ph;
        beat.next_src_x = sx[cscr_pkg::SRC_W-1:0];
        beat.next_src_y = sy[cscr_pkg::SRC_W-1:0];
        return beat;
    endfunction

    // Write one geometry register and track it
    task automatic write_reg(input cscr_pkg::t_cfg_index idx, input logic [11:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cscr_pkg::CFG_CROP_LEFT:    geom.crop_left    = value;
            cscr_pkg::CFG_CROP_TOP:     geom.crop_top     = value;
            cscr_pkg::CFG_CROP_WIDTH:   geom.crop_width   = value;
            cscr_pkg::CFG_CROP_HEIGHT:  geom.crop_height  = value;
            cscr_pkg::CFG_PLACE_LEFT:   geom.place_left   = value[cscr_pkg::COL_W-1:0];
            cscr_pkg::CFG_PLACE_TOP:    geom.place_top    = value[cscr_pkg::ROW_W-1:0];
            cscr_pkg::CFG_PLACE_WIDTH:  geom.place_width  = value[cscr_pkg::COL_W-1:0];
            cscr_pkg::CFG_PLACE_HEIGHT: geom.place_height = value[cscr_pkg::ROW_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_geometry(input logic [11:0] cl, ct, cw, ch,
                                    input logic [11:0] pl, pt, pw, ph);
        write_reg(cscr_pkg::CFG_CROP_LEFT, cl);
        write_reg(cscr_pkg::CFG_CROP_TOP, ct);
        write_reg(cscr_pkg::CFG_CROP_WIDTH, cw);
        write_reg(cscr_pkg::CFG_CROP_HEIGHT, ch);
        write_reg(cscr_pkg::CFG_PLACE_LEFT, pl);
        write_reg(cscr_pkg::CFG_PLACE_TOP, pt);
        write_reg(cscr_pkg::CFG_PLACE_WIDTH, pw);
        write_reg(cscr_pkg::CFG_PLACE_HEIGHT, ph);
        settings_run++;
    endtask

    // Present one pixel beat after a random gap (none in steady phases) and hold until accepted
    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cb,
                              input logic [7:0] cr);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.luma_sample <= luma;
        pix_if.chroma_blue <= cb;
        pix_if.chroma_red  <= cr;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pending_pixels.push_back(advance_pixel(luma, cb, cr));
        pixels_sent++;
    endtask

    // Drop valid, wait for every expected beat, then let the back end settle
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Clamp corners and neutral chroma at the reset geometry
    task automatic test_color_extremes();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd16, 8'd128, 8'd128);
        send_pixel(8'd235, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        drain();
    endtask

    // Zero-sized destination acts as one pixel: every beat ends a frame
    task automatic test_zero_size();
        program_geometry(12'd0, 12'd0, 12'd320, 12'd240, 12'd0, 12'd0, 12'd0, 12'd0);
        send_pixel(8'd100, 8'd50, 8'd200);
        send_pixel(8'd200, 8'd200, 8'd50);
        drain();
    endtask

    // Shrink the height while the row sits past it
    task automatic test_beyond_rect();
        program_geometry(12'd10, 12'd20, 12'd64, 12'd48, 12'd5, 12'd7, 12'd3, 12'd200);
        repeat (7) send_pixel(pick_byte(), pick_byte(), pick_byte());
        drain();
        write_reg(cscr_pkg::CFG_PLACE_HEIGHT, 12'd1);
        repeat (3) send_pixel(pick_byte(), pick_byte(), pick_byte());
        drain();
    endtask

    // Large offsets and largest crop sizes: source coordinates wrap
    task automatic test_wrap_extremes();
        program_geometry(12'd4094, 12'd4094, 12'd4095, 12'd4095,
                         12'hFFF, 12'hFFF, 12'd2, 12'd2);
        repeat (4) send_pixel(pick_byte(), pick_byte(), pick_byte());
        drain();
    endtask

    // Random geometries, mostly whole small frames with random pixels
    task automatic test_random_frames();
        logic [11:0] cl, ct, cw, ch, pl, pt, pw, ph;
        int          eff_w, eff_h, frame, count, sent;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            cl = 12'($urandom_range(0, 4094));
            ct = 12'($urandom_range(0, 4094));
            cw = 12'($urandom_range(1, 4095));
            ch = 12'($urandom_range(1, 4095));
            pl = 12'($urandom_range(0, 319));
            pt = 12'($urandom_range(0, 239));
            case ($urandom_range(0, 9))
                6: begin
                    // Tall and narrow near the bottom: index wraps
                    pw = 12'($urandom_range(1, 2));
                    ph = 12'($urandom_range(150, 255) | ($urandom_range(0, 15) << 8));
                    pt = 12'($urandom_range(200, 255));
                    pl = 12'($urandom_range(0, 4095));
                end
                7: begin
                    cl = 12'($urandom); ct = 12'($urandom);
                    cw = 12'($urandom); ch = 12'($urandom);
                    pl = 12'($urandom); pt = 12'($urandom);
                    pw = 12'($urandom); ph = 12'($urandom);
                end
                8: begin
                    cl = $urandom_range(0, 1) ? 12'd4094 : 12'd0;
                    ct = $urandom_range(0, 1) ? 12'd4094 : 12'd0;
                    cw = $urandom_range(0, 1) ? 12'd4095 : 12'd1;
                    ch = $urandom_range(0, 1) ? 12'd4095 : 12'd1;
                    pl = $urandom_range(0, 1) ? 12'd319 : 12'd0;
                    pt = $urandom_range(0, 1) ? 12'd239 : 12'd0;
                    pw = $urandom_range(0, 1) ? 12'd320 : 12'd1;
                    ph = $urandom_range(0, 1) ? 12'd240 : 12'd1;
                end
                9: begin
                    pw = 12'($urandom_range(200, 320));
                    ph = 12'($urandom_range(1, 2));
                end
                default: begin
                    pw = 12'($urandom_range(1, 16));
                    ph = 12'($urandom_range(1, 8));
                end
            endcase
            program_geometry(cl, ct, cw, ch, pl, pt, pw, ph);
            eff_w = (pw[cscr_pkg::COL_W-1:0] == '0) ? 1 : int'(pw[cscr_pkg::COL_W-1:0]);
            eff_h = (ph[cscr_pkg::ROW_W-1:0] == '0) ? 1 : int'(ph[cscr_pkg::ROW_W-1:0]);
            frame = eff_w * eff_h;
            if (frame > 700) count = $urandom_range(20, 200);
            else count = frame + $urandom_range(0, 3);
            // Stop some phases mid-frame
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
            // Hold the total near the pixel budget
            if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
            steady = ($urandom_range(0, 3) == 0);
            repeat (count) send_pixel(pick_byte(), pick_byte(), pick_byte());
            sent += count;
            drain();
            steady = 1'b0;
        end
    endtask

    // Output side: random stalls on ready
    initial begin : ready_driver
        int stall;
        rgb_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            stall = steady ? 0 : pick_gap();
            if (stall == 0) begin
                rgb_if.ready <= 1'b1;
            end else begin
                rgb_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                rgb_if.ready <= 1'b1;
            end
        end
    end

    // Compare each output beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_rgb_beat want;
        if (i_rst_n === 1'b1 && rgb_if.valid === 1'b1 && rgb_if.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected beat: color %h dest_index %0d",
                       rgb_if.color, rgb_if.dest_index);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (rgb_if.color !== want.color) begin
                    $error("color: expected %h, got %h", want.color, rgb_if.color);
                    mismatches++;
                end
                if (rgb_if.dest_index !== want.dest_index) begin
                    $error("dest_index: expected %0d, got %0d",
                           want.dest_index, rgb_if.dest_index);
                    mismatches++;
                end
                if (rgb_if.next_src_x !== want.next_src_x) begin
                    $error("next_src_x: expected %0d, got %0d",
                           want.next_src_x, rgb_if.next_src_x);
                    mismatches++;
                end
                if (rgb_if.next_src_y !== want.next_src_y) begin
                    $error("next_src_y: expected %0d, got %0d",
                           want.next_src_y, rgb_if.next_src_y);
                    mismatches++;
                end
                if (rgb_if.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0b, got %0b",
                           want.frame_last, rgb_if.frame_last);
                    mismatches++;
                end
                if (want.frame_last) frames_seen++;
            end
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (rgb_if.valid && rgb_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= cscr_pkg::CFG_CROP_LEFT;
        i_cfg_data         <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.luma_sample <= '0;
        pix_if.chroma_blue <= '0;
        pix_if.chroma_red  <= '0;
        geom.crop_left    = '0;
        geom.crop_top     = '0;
        geom.crop_width   = cscr_pkg::CROP_WIDTH_RST;
        geom.crop_height  = cscr_pkg::CROP_HEIGHT_RST;
        geom.place_left   = '0;
        geom.place_top    = '0;
        geom.place_width  = cscr_pkg::PLACE_WIDTH_RST;
        geom.place_height = cscr_pkg::PLACE_HEIGHT_RST;
        col_pos = '0;
        row_pos = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_color_extremes();
        test_zero_size();
        test_beyond_rect();
        test_wrap_extremes();
        test_random_frames();
        drain();

        $display("covered %0d pixels over %0d geometry settings, %0d frame ends",
                 pixels_sent, settings_run, frames_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/cscr_pkg.sv
rtl/cscr_pix_if.sv
rtl/cscr_rgb_if.sv
rtl/cscr_fifo.sv
rtl/cscr_div.sv
rtl/cscr_front.sv
rtl/cscr_back.sv
rtl/crop_scale_ycbcr_to_rgb.sv
tb/crop_scale_ycbcr_to_rgb_tb.sv
